FILE: design/srr_pkg.sv
package srr_pkg;

  localparam int SEQ_W  = 3;
  localparam int DATA_W = 64;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

endpackage

FILE: design/srr_ram.sv
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/selective_repeat_receiver_unit.sv
// A packet with a bad checksum is accepted and gives nothing.
// A good packet gives its ack from S_CHECK once nothing is buffered in order and
// the output is free; each in-order delivery before it goes S_CHECK (payload RAM
// read issued), then S_READ (data word loaded into the output) and back to S_CHECK.
// Reset clears the window base, the head pointer, the slot filled bits and the
// output valid; the payload RAM is not cleared.
module selective_repeat_receiver_unit
  import srr_pkg::*;
#(
  parameter int SEQ_SPACE    = 8,
  parameter int WINDOW_SIZE  = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [SEQ_W-1:0]  seq_num_i,
  input  logic              checksum_ok_i,
  input  logic [DATA_W-1:0] payload_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [DATA_W-1:0] data_o,
  output logic [SEQ_W-1:0]  ack_num_o,
  output logic              last_o
);

  localparam int BW = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
  localparam int SW = ((BW > SEQ_W) ? BW : SEQ_W) + 1;
  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int PW = IW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_READ
  } state_e;

  state_e                  state_q;
  logic [BW-1:0]           base_q;
  logic [IW-1:0]           hp_q;
  logic [WINDOW_SIZE-1:0]  filled_q;
  logic [SEQ_W-1:0]        seq_q;
  logic                    out_valid_q;
  logic                    kind_q;
  logic [DATA_W-1:0]       data_q;
  logic [SEQ_W-1:0]        ack_q;
  logic                    last_q;

  logic [SW-1:0]           seq_red;
  logic [SW-1:0]           off_sum;
  logic [SW-1:0]           offset;
  logic                    in_win;
  logic [PW-1:0]           phys_sum;
  logic [IW-1:0]           phys;
  logic                    in_acc;
  logic                    store;
  logic                    out_free;
  logic                    out_load;
  logic                    head_full;
  logic                    ram_we;
  logic                    ram_re;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic [BW-1:0]           base_inc;
  logic [IW-1:0]           hp_inc;

  // reduce the sequence number into the space, then offset from the base
  always_comb begin
    seq_red = SW'(seq_num_i);
    for (int k = 0; k < 4; k++) begin
      if (seq_red >= SW'(SEQ_SPACE)) begin
        seq_red = seq_red - SW'(SEQ_SPACE);
      end
    end
    off_sum = seq_red + SW'(SEQ_SPACE) - SW'(base_q);
    offset  = (off_sum >= SW'(SEQ_SPACE)) ? off_sum - SW'(SEQ_SPACE) : off_sum;
  end

  assign in_win   = 32'(offset) < WINDOW_SIZE;
  // only meaningful inside the window, where offset < WINDOW_SIZE
  assign phys_sum = PW'(hp_q) + PW'(offset);
  assign phys     = (phys_sum >= PW'(WINDOW_SIZE)) ?
                    IW'(phys_sum - PW'(WINDOW_SIZE)) : IW'(phys_sum);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign store      = in_acc && checksum_ok_i && in_win && !filled_q[phys];
  assign out_free   = !out_valid_q || out_ready_i;
  assign head_full  = filled_q[hp_q];
  assign out_load   = out_free &&
                      ((state_q == S_CHECK && !head_full) || state_q == S_READ);

  assign ram_we = store;
  assign ram_re = (state_q == S_CHECK) && head_full;

  assign base_inc = (base_q == BW'(SEQ_SPACE - 1)) ? '0 : base_q + 1'b1;
  assign hp_inc   = (hp_q == IW'(WINDOW_SIZE - 1)) ? '0 : hp_q + 1'b1;

  srr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (WINDOW_SIZE)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (phys),
    .wdata_i (payload_i[PAYLOAD_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (hp_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      hp_q        <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && checksum_ok_i) begin
            seq_q   <= seq_num_i;
            state_q <= S_CHECK;
            if (store) begin
              filled_q[phys] <= 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (head_full) begin
            // slot read issued now; retire it and slide the window
            filled_q[hp_q] <= 1'b0;
            hp_q           <= hp_inc;
            base_q         <= base_inc;
            state_q        <= S_READ;
          end else if (out_free) begin
            kind_q      <= KIND_ACK;
            data_q      <= '0;
            ack_q       <= seq_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            kind_q      <= KIND_DATA;
            data_q      <= DATA_W'(ram_rdata);
            ack_q       <= '0;
            last_q      <= 1'b0;
            state_q     <= S_CHECK;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign ack_num_o   = ack_q;
  assign last_o      = last_q;

  a_bad_pkt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !checksum_ok_i |=> state_q == S_IDLE)
    else $error("corrupt packet left the idle state");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("slot RAM written and read in the same cycle");

  a_store_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> state_q == S_CHECK && filled_q != '0)
    else $error("stored packet not marked as filled");

  a_window_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CHECK |=> $stable(base_q) && $stable(hp_q))
    else $error("window moved outside the drain check");

  a_idle_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !head_full)
    else $error("in-order slot left undelivered at idle");

endmodule
